[hw/rtl/breakpoint_address_table_defines.svh]
// assertion helpers for the breakpoint address table
`ifndef BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH
`define BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BAT_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bat assertion failed");

// next-cycle implication, checked outside reset
`define BAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bat assertion failed");

`endif

[hw/rtl/bat_pkg.sv]
package bat_pkg;

  localparam int SLOTS  = 8;
  localparam int FUNC_W = 2;
  localparam int ADDR_W = 16;
  localparam int SLOT_W = 8;
  localparam int USED_W = 4;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [USED_W-1:0] used_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    func_t func;
    addr_t address;
    slot_t slot;
  } req_t;

  typedef struct packed {
    logic  ok;
    used_t entries_used;
  } rsp_t;

endpackage

[hw/rtl/bat_table.sv]
`include "breakpoint_address_table_defines.svh"

module bat_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bat_pkg::req_t req,
  output bat_pkg::rsp_t rsp
);

  bat_pkg::addr_t addr_slots [bat_pkg::SLOTS];
  bat_pkg::cnt_t  count;
  bat_pkg::cnt_t  count_next;

  logic [bat_pkg::SLOTS-1:0] hit_vec;
  logic hit;
  logic room;
  logic clr_ok;
  logic ok;

  always_comb begin
    for (int i = 0; i < bat_pkg::SLOTS; i++) begin
      hit_vec[i] = (bat_pkg::cnt_t'(i) < count) && (addr_slots[i] == req.address);
    end
    hit    = |hit_vec;
    room   = count < bat_pkg::cnt_t'(bat_pkg::SLOTS);
    clr_ok = (req.slot != '0) && (req.slot <= bat_pkg::slot_t'(count));
  end

  always_comb begin
    ok         = 1'b0;
    count_next = count;
    case (req.func)
      bat_pkg::FUNC_SET: begin
        ok = hit || room;
        if (!hit && room) count_next = count + bat_pkg::cnt_t'(1);
      end
      bat_pkg::FUNC_CLEAR: begin
        ok = clr_ok;
        if (clr_ok) count_next = count - bat_pkg::cnt_t'(1);
      end
      bat_pkg::FUNC_QUERY: begin
        ok = hit;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign rsp.ok           = ok;
  assign rsp.entries_used = bat_pkg::used_t'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (en) begin
      count <= count_next;
    end
  end

  // append on a new set, shift down above the cleared slot
  always_ff @(posedge clk) begin
    if (en) begin
      case (req.func)
        bat_pkg::FUNC_SET: begin
          if (!hit && room) begin
            for (int i = 0; i < bat_pkg::SLOTS; i++) begin
              if (bat_pkg::cnt_t'(i) == count) addr_slots[i] <= req.address;
            end
          end
        end
        bat_pkg::FUNC_CLEAR: begin
          if (clr_ok) begin
            for (int i = 0; i < bat_pkg::SLOTS - 1; i++) begin
              if (bat_pkg::slot_t'(i + 1) >= req.slot) addr_slots[i] <= addr_slots[i + 1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `BAT_ASSERT(count_in_range, 1'b1, count <= bat_pkg::cnt_t'(bat_pkg::SLOTS))
  `BAT_ASSERT_NEXT(query_keeps_count, !rst && en && req.func == bat_pkg::FUNC_QUERY, $stable(count))
  `BAT_ASSERT_NEXT(clear_drops_one, !rst && en && req.func == bat_pkg::FUNC_CLEAR && ok, count == $past(count) - bat_pkg::cnt_t'(1))

endmodule

[hw/rtl/breakpoint_address_table.sv]
// Breakpoint address table: an ordered list of up to SLOTS 16-bit addresses, empty
// after reset, driven by set, clear-by-slot and query requests over valid/ready.
// One request is taken every cycle when the response side keeps up; each accepted
// request goes through the request register and then the response register. The
// rate is set by the table update, where compare against all entries, append or
// shift-down, and the count update all finish combinationally between the two
// registers. Responses come back in request order, one per request.
module breakpoint_address_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bat_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bat_pkg::rsp_t rsp
);

  logic          s1_valid;
  bat_pkg::req_t s1;
  bat_pkg::rsp_t res;
  logic          advance;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) s1 <= req;
  end

  bat_table u_table (
    .clk (clk),
    .rst (rst),
    .en  (s1_valid && advance),
    .req (s1),
    .rsp (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) rsp <= res;
  end

endmodule
